// ===== hdl/sbsm_pkg.sv =====
// Shared types, codes and helpers for the serial bank switch mapper.
`timescale 1ns / 1ps

package sbsm_pkg;

    typedef enum logic [1:0] {
        OP_REG_WRITE = 2'd0,
        OP_PRG_READ  = 2'd1,
        OP_CHR_READ  = 2'd2,
        OP_CHR_WRITE = 2'd3
    } op_t;

    typedef struct packed {
        op_t         operation;
        logic [15:0] address;
        logic [7:0]  data;
    } req_t;

    typedef struct packed {
        logic [17:0] mapped_address;
        logic        memory_write_enable;
        logic [1:0]  mirroring;
    } rsp_t;

    typedef struct packed {
        logic [1:0] prg_mode;
        logic       chr_mode;
        logic [3:0] prg_bank;
        logic [4:0] chr_low;
        logic [4:0] chr_high;
    } map_state_t;

    localparam logic [1:0] CFG_PRG_BANK_COUNT = 2'd0;
    localparam logic [1:0] CFG_CHR_IS_RAM     = 2'd1;
    localparam logic [1:0] CFG_INIT_MIRROR    = 2'd2;

    localparam logic [1:0] TGT_CONTROL  = 2'd0;
    localparam logic [1:0] TGT_CHR_LOW  = 2'd1;
    localparam logic [1:0] TGT_CHR_HIGH = 2'd2;
    localparam logic [1:0] TGT_PRG_BANK = 2'd3;

    localparam logic [1:0] PRG_MODE_32K_0     = 2'd0;
    localparam logic [1:0] PRG_MODE_32K_1     = 2'd1;
    localparam logic [1:0] PRG_MODE_FIX_FIRST = 2'd2;
    localparam logic [1:0] PRG_MODE_FIX_LAST  = 2'd3;

    localparam logic       CHR_MODE_8K = 1'b0;

    localparam logic [2:0] LOAD_LEN        = 3'd5;
    localparam int         LOAD_CLEAR_BIT  = 7;
    localparam logic [4:0] PRG_COUNT_RESET = 5'd16;
    localparam logic [1:0] MIRROR_RESET    = 2'd2;

    localparam map_state_t MAP_STATE_RESET = '{
        prg_mode: PRG_MODE_FIX_LAST,
        chr_mode: 1'b0,
        prg_bank: 4'd0,
        chr_low:  5'd0,
        chr_high: 5'd0
    };

    // Mask of the usable program banks: clamp to the limit, round down to a power of two.
    function automatic logic [3:0] prg_bank_mask(input logic [4:0] count,
                                                 input logic [4:0] max_banks);
        logic [4:0] lim;
        logic [3:0] mask;
        lim  = (count > max_banks) ? max_banks : count;
        mask = 4'b0001;
        for (int i = 2; i <= 4; i++)
        begin
            if (lim >= (5'd1 << i))
            begin
                mask = 4'((5'd1 << i) - 5'd1);
            end
        end
        return mask;
    endfunction

endpackage

// ===== hdl/sbsm_xlate.sv =====
// Address translation for program and character accesses.
`timescale 1ns / 1ps

module sbsm_xlate (
    input  sbsm_pkg::req_t       item,
    input  sbsm_pkg::map_state_t st,
    input  logic [3:0]           prg_mask,
    input  logic                 chr_is_ram,
    input  logic [1:0]           mirror_next,
    output sbsm_pkg::rsp_t       result
);

    logic       prg_slot;
    logic [3:0] prg_bank;
    logic [17:0] prg_addr;
    logic       chr_slot;
    logic [4:0] chr_bank;
    logic [17:0] chr_addr;

    assign prg_slot = item.address[15] & item.address[14];
    assign chr_slot = item.address[12];

    always_comb
    begin
        case (st.prg_mode)
            sbsm_pkg::PRG_MODE_32K_0,
            sbsm_pkg::PRG_MODE_32K_1: prg_bank = {st.prg_bank[3:1], prg_slot};
            sbsm_pkg::PRG_MODE_FIX_FIRST: prg_bank = prg_slot ? st.prg_bank : 4'd0;
            sbsm_pkg::PRG_MODE_FIX_LAST: prg_bank = prg_slot ? 4'hF : st.prg_bank;
            default: prg_bank = st.prg_bank;
        endcase
    end

    assign prg_addr = {prg_bank & prg_mask, item.address[13:0]};

    always_comb
    begin
        if (st.chr_mode == sbsm_pkg::CHR_MODE_8K)
        begin
            chr_bank = {st.chr_low[4:1], chr_slot};
        end
        else
        begin
            chr_bank = chr_slot ? st.chr_high : st.chr_low;
        end
    end

    assign chr_addr = chr_is_ram ? {5'd0, item.address[12:0]}
                                 : {1'b0, chr_bank, item.address[11:0]};

    always_comb
    begin
        result.mirroring = mirror_next;
        case (item.operation)
            sbsm_pkg::OP_REG_WRITE:
            begin
                result.mapped_address      = 18'd0;
                result.memory_write_enable = 1'b0;
            end
            sbsm_pkg::OP_PRG_READ:
            begin
                result.mapped_address      = prg_addr;
                result.memory_write_enable = 1'b0;
            end
            sbsm_pkg::OP_CHR_READ:
            begin
                result.mapped_address      = chr_addr;
                result.memory_write_enable = 1'b0;
            end
            sbsm_pkg::OP_CHR_WRITE:
            begin
                result.mapped_address      = chr_addr;
                result.memory_write_enable = chr_is_ram;
            end
            default:
            begin
                result.mapped_address      = 18'd0;
                result.memory_write_enable = 1'b0;
            end
        endcase
    end

endmodule

// ===== hdl/sbsm_loader.sv =====
// Serial loader and bank, mode and mirroring registers.
`timescale 1ns / 1ps

module sbsm_loader (
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 fire,
    input  sbsm_pkg::req_t       item,
    input  logic                 cfg_mirror_we,
    input  logic [1:0]           cfg_mirror,
    output sbsm_pkg::map_state_t st,
    output logic [1:0]           mirror_next
);

    sbsm_pkg::map_state_t st_reg;
    sbsm_pkg::map_state_t st_next;
    logic [4:0] shift_reg;
    logic [4:0] shift_next;
    logic [2:0] count_reg;
    logic [2:0] count_next;
    logic [1:0] mirror_reg;
    logic [4:0] shifted;
    logic [2:0] count_inc;

    assign shifted   = {item.data[0], shift_reg[4:1]};
    assign count_inc = count_reg + 3'd1;

    always_comb
    begin
        st_next     = st_reg;
        shift_next  = shift_reg;
        count_next  = count_reg;
        mirror_next = mirror_reg;
        if (item.operation == sbsm_pkg::OP_REG_WRITE)
        begin
            if (item.data[sbsm_pkg::LOAD_CLEAR_BIT])
            begin
                shift_next       = 5'd0;
                count_next       = 3'd0;
                st_next.prg_mode = sbsm_pkg::PRG_MODE_FIX_LAST;
            end
            else if (count_inc == sbsm_pkg::LOAD_LEN)
            begin
                shift_next = 5'd0;
                count_next = 3'd0;
                case (item.address[14:13])
                    sbsm_pkg::TGT_CONTROL:
                    begin
                        mirror_next      = shifted[1:0];
                        st_next.prg_mode = shifted[3:2];
                        st_next.chr_mode = shifted[4];
                    end
                    sbsm_pkg::TGT_CHR_LOW:  st_next.chr_low  = shifted;
                    sbsm_pkg::TGT_CHR_HIGH: st_next.chr_high = shifted;
                    sbsm_pkg::TGT_PRG_BANK: st_next.prg_bank = shifted[3:0];
                    default:                st_next.prg_bank = shifted[3:0];
                endcase
            end
            else
            begin
                shift_next = shifted;
                count_next = count_inc;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            st_reg     <= sbsm_pkg::MAP_STATE_RESET;
            shift_reg  <= 5'd0;
            count_reg  <= 3'd0;
            mirror_reg <= sbsm_pkg::MIRROR_RESET;
        end
        else if (cfg_mirror_we)
        begin
            mirror_reg <= cfg_mirror;
        end
        else if (fire)
        begin
            st_reg     <= st_next;
            shift_reg  <= shift_next;
            count_reg  <= count_next;
            mirror_reg <= mirror_next;
        end
    end

    assign st = st_reg;

endmodule

// ===== hdl/serial_bank_switch_mapper.sv =====
// Top level of the serial bank switch mapper: word registers, configuration, control.
// A word passes the input register, then the result register; each is one stage.
// Throughput: one word per cycle while the result side does not stall.
// Stall on the result side holds the result register and back-pressures the input register.
// Reset (rst_n low, asynchronous) clears the loader, sets program mode 3 and the
// configuration to 16 banks, banked character ROM and vertical mirroring.
`timescale 1ns / 1ps

module serial_bank_switch_mapper #(
    parameter int MAX_PRG_BANKS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    output logic           req_stall,
    input  sbsm_pkg::req_t req,
    output logic           rsp_valid,
    input  logic           rsp_stall,
    output sbsm_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    output logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [4:0]     cfg_data
);

    localparam logic [4:0] MAX_BANKS = 5'(MAX_PRG_BANKS);

    logic                 s1_valid_reg;
    sbsm_pkg::req_t       s1_item_reg;
    logic                 rsp_valid_reg;
    sbsm_pkg::rsp_t       rsp_reg;
    logic [4:0]           prg_count_reg;
    logic                 chr_ram_reg;
    logic                 advance;
    logic                 accept;
    logic                 cfg_write;
    logic                 cfg_mirror_we;
    logic [3:0]           prg_mask;
    logic [1:0]           mirror_next;
    sbsm_pkg::map_state_t st;
    sbsm_pkg::rsp_t       result;

    assign advance   = s1_valid_reg && (!rsp_valid_reg || !rsp_stall);
    assign req_stall = s1_valid_reg && !advance;
    assign accept    = req_valid && !req_stall;
    assign cfg_ready = 1'b1;
    assign cfg_write = cfg_valid && cfg_ready;
    assign cfg_mirror_we = cfg_write && (cfg_index == sbsm_pkg::CFG_INIT_MIRROR);
    assign prg_mask  = sbsm_pkg::prg_bank_mask(prg_count_reg, MAX_BANKS);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            prg_count_reg <= sbsm_pkg::PRG_COUNT_RESET;
            chr_ram_reg   <= 1'b0;
        end
        else if (cfg_write)
        begin
            case (cfg_index)
                sbsm_pkg::CFG_PRG_BANK_COUNT: prg_count_reg <= cfg_data;
                sbsm_pkg::CFG_CHR_IS_RAM:     chr_ram_reg   <= cfg_data[0];
                default:                      ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            s1_valid_reg  <= 1'b0;
            rsp_valid_reg <= 1'b0;
        end
        else
        begin
            if (accept)
            begin
                s1_valid_reg <= 1'b1;
            end
            else if (advance)
            begin
                s1_valid_reg <= 1'b0;
            end
            if (advance)
            begin
                rsp_valid_reg <= 1'b1;
            end
            else if (!rsp_stall)
            begin
                rsp_valid_reg <= 1'b0;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (accept)
        begin
            s1_item_reg <= req;
        end
        if (advance)
        begin
            rsp_reg <= result;
        end
    end

    sbsm_loader u_loader (
        .clk           (clk),
        .rst_n         (rst_n),
        .fire          (advance),
        .item          (s1_item_reg),
        .cfg_mirror_we (cfg_mirror_we),
        .cfg_mirror    (cfg_data[1:0]),
        .st            (st),
        .mirror_next   (mirror_next)
    );

    sbsm_xlate u_xlate (
        .item        (s1_item_reg),
        .st          (st),
        .prg_mask    (prg_mask),
        .chr_is_ram  (chr_ram_reg),
        .mirror_next (mirror_next),
        .result      (result)
    );

    assign rsp_valid = rsp_valid_reg;
    assign rsp       = rsp_reg;

endmodule

// ===== hdl/sbsm_checker.sv =====
// Port-level checker for the serial bank switch mapper and its bind.
`timescale 1ns / 1ps

module sbsm_checker (
    input logic           clk,
    input logic           rst_n,
    input logic           req_valid,
    input logic           req_stall,
    input logic           rsp_valid,
    input logic           rsp_stall,
    input sbsm_pkg::rsp_t rsp
);

    // hold a stalled result word
    a_rsp_hold: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp_stall |=> rsp_valid && $stable(rsp))
        else $error("stalled result word changed or dropped");

    // stall input only while the result word is blocked
    a_stall_cause: assert property (@(posedge clk) disable iff (!rst_n)
        req_stall |-> rsp_valid && rsp_stall)
        else $error("input stalled while output side is free");

    // advance an accepted word to the output when the output side is free
    a_latency: assert property (@(posedge clk) disable iff (!rst_n)
        (req_valid && !req_stall) ##1 !rsp_stall |=> rsp_valid)
        else $error("accepted word did not reach the result register");

    // RAM writes stay inside the 8 KB character window
    a_we_range: assert property (@(posedge clk) disable iff (!rst_n)
        rsp_valid && rsp.memory_write_enable |-> rsp.mapped_address[17:13] == 5'd0)
        else $error("character RAM write outside 8 KB");

endmodule

bind serial_bank_switch_mapper sbsm_checker u_sbsm_checker (
    .clk       (clk),
    .rst_n     (rst_n),
    .req_valid (req_valid),
    .req_stall (req_stall),
    .rsp_valid (rsp_valid),
    .rsp_stall (rsp_stall),
    .rsp       (rsp)
);

// ===== tb/sbsm_checker.sv =====
// Checker for the serial bank switch mapper: follows every channel, predicts and compares words.
`timescale 1ns / 1ps

module sbsm_scoreboard #(
    parameter int MAX_BANKS = 16
) (
    input  logic           clk,
    input  logic           rst_n,
    input  logic           req_valid,
    input  logic           req_stall,
    input  sbsm_pkg::req_t req,
    input  logic           rsp_valid,
    input  logic           rsp_stall,
    input  sbsm_pkg::rsp_t rsp,
    input  logic           cfg_valid,
    input  logic           cfg_ready,
    input  logic [1:0]     cfg_index,
    input  logic [4:0]     cfg_data,
    output int             errors,
    output int             pending,
    output int             words_in,
    output int             words_out
);

    logic [4:0] ld_shift;
    logic [2:0] ld_count;
    logic [1:0] prg_mode;
    logic       chr_mode;
    logic [1:0] mirror;
    logic [3:0] prg_bank;
    logic [4:0] chr_low;
    logic [4:0] chr_high;

    logic [4:0] cfg_banks;
    logic       cfg_chr_ram;

    sbsm_pkg::rsp_t expected_words[$];
    int   mismatch_count;
    int   in_count;
    int   out_count;

    assign errors    = mismatch_count;
    assign words_in  = in_count;
    assign words_out = out_count;

    function automatic logic [3:0] usable_bank_mask();
        int lim;
        int p;
        lim = (cfg_banks > MAX_BANKS) ? MAX_BANKS : int'(cfg_banks);
        p   = 2;
        while (p * 2 <= lim)
        begin
            p = p * 2;
        end
        return 4'(p - 1);
    endfunction

    function automatic logic [17:0] prg_offset(input logic [15:0] a);
        logic       slot;
        logic [3:0] mask;
        logic [3:0] bank;
        slot = (a >= 16'hC000);
        mask = usable_bank_mask();
        case (prg_mode)
            sbsm_pkg::PRG_MODE_FIX_FIRST: bank = slot ? prg_bank : 4'd0;
            sbsm_pkg::PRG_MODE_FIX_LAST:  bank = slot ? mask : prg_bank;
            default:                      bank = {prg_bank[3:1], 1'b0} + {3'd0, slot};
        endcase
        bank = bank & mask;
        return {bank, a[13:0]};
    endfunction

    function automatic logic [17:0] chr_offset(input logic [15:0] a);
        logic [4:0] bank;
        if (chr_mode == sbsm_pkg::CHR_MODE_8K)
            bank = {chr_low[4:1], a[12]};
        else
            bank = a[12] ? chr_high : chr_low;
        if (cfg_chr_ram)
            return {5'd0, a[12:0]};
        else
            return {1'b0, bank, a[11:0]};
    endfunction

    function automatic void shift_in(input logic [15:0] a, input logic [7:0] d);
        if (d[sbsm_pkg::LOAD_CLEAR_BIT])
        begin
            ld_shift = '0;
            ld_count = '0;
            prg_mode = sbsm_pkg::PRG_MODE_FIX_LAST;
        end
        else
        begin
            ld_shift = {d[0], ld_shift[4:1]};
            ld_count = ld_count + 3'd1;
            if (ld_count == sbsm_pkg::LOAD_LEN)
            begin
                case (a[14:13])
                    sbsm_pkg::TGT_CONTROL:
                    begin
                        mirror   = ld_shift[1:0];
                        prg_mode = ld_shift[3:2];
                        chr_mode = ld_shift[4];
                    end
                    sbsm_pkg::TGT_CHR_LOW:  chr_low  = ld_shift;
                    sbsm_pkg::TGT_CHR_HIGH: chr_high = ld_shift;
                    default:                prg_bank = ld_shift[3:0];
                endcase
                ld_shift = '0;
                ld_count = '0;
            end
        end
    endfunction

    function automatic sbsm_pkg::rsp_t translate_word(input sbsm_pkg::req_t w);
        sbsm_pkg::rsp_t r;
        r = '0;
        case (w.operation)
            sbsm_pkg::OP_REG_WRITE: shift_in(w.address, w.data);
            sbsm_pkg::OP_PRG_READ:  r.mapped_address = prg_offset(w.address);
            default:
            begin
                r.mapped_address      = chr_offset(w.address);
                r.memory_write_enable = (w.operation == sbsm_pkg::OP_CHR_WRITE) && cfg_chr_ram;
            end
        endcase
        r.mirroring = mirror;
        return r;
    endfunction

    task automatic flag_mismatch(input string why, input sbsm_pkg::rsp_t want,
                                 input sbsm_pkg::rsp_t got);
        mismatch_count++;
        if (mismatch_count <= 10)
            $display("%0t: result %0d %s: expected addr=%05h we=%b mirror=%0d,",
                     $realtime, out_count, why, want.mapped_address,
                     want.memory_write_enable, want.mirroring,
                     " got addr=%05h we=%b mirror=%0d",
                     got.mapped_address, got.memory_write_enable, got.mirroring);
    endtask

    always @(posedge clk or negedge rst_n)
    begin : watch
        sbsm_pkg::rsp_t want;
        if (!rst_n)
        begin
            cfg_banks      = sbsm_pkg::PRG_COUNT_RESET;
            cfg_chr_ram    = 1'b0;
            ld_shift       = '0;
            ld_count       = '0;
            prg_mode       = sbsm_pkg::PRG_MODE_FIX_LAST;
            chr_mode       = 1'b0;
            mirror         = sbsm_pkg::MIRROR_RESET;
            prg_bank       = '0;
            chr_low        = '0;
            chr_high       = '0;
            mismatch_count = 0;
            in_count       = 0;
            out_count      = 0;
            expected_words.delete();
            pending <= 0;
        end
        else
        begin
            if (cfg_valid && cfg_ready)
            begin
                case (cfg_index)
                    sbsm_pkg::CFG_PRG_BANK_COUNT: cfg_banks = cfg_data;
                    sbsm_pkg::CFG_CHR_IS_RAM:     cfg_chr_ram = cfg_data[0];
                    sbsm_pkg::CFG_INIT_MIRROR:    mirror = cfg_data[1:0];
                    default: ;
                endcase
            end
            if (rsp_valid && !rsp_stall)
            begin
                if (expected_words.size() == 0)
                begin
                    flag_mismatch("with nothing expected", '0, rsp);
                end
                else
                begin
                    want = expected_words.pop_front();
                    if (rsp.mapped_address !== want.mapped_address
                        || rsp.memory_write_enable !== want.memory_write_enable
                        || rsp.mirroring !== want.mirroring)
                        flag_mismatch("differs", want, rsp);
                end
                out_count++;
            end
            if (req_valid && !req_stall)
            begin
                expected_words.push_back(translate_word(req));
                in_count++;
            end
            pending <= expected_words.size();
        end
    end

endmodule

// ===== tb/tb_serial_bank_switch_mapper.sv =====
// Testbench top for the serial bank switch mapper: stimulus, configuration phases and verdict.
`timescale 1ns / 1ps

module tb_serial_bank_switch_mapper;

    localparam int MAX_BANKS   = 16;
    localparam int PHASE_WORDS = 70;

    logic           clk;
    logic           rst_n;
    logic           req_valid;
    logic           req_stall;
    sbsm_pkg::req_t req;
    logic           rsp_valid;
    logic           rsp_stall;
    sbsm_pkg::rsp_t rsp;
    logic           cfg_valid;
    logic           cfg_ready;
    logic [1:0]     cfg_index;
    logic [4:0]     cfg_data;

    int errors;
    int pending;
    int words_in;
    int words_out;
    int settings_done;
    bit calm;

    serial_bank_switch_mapper #(
        .MAX_PRG_BANKS(MAX_BANKS)
    ) uut (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data)
    );

    sbsm_scoreboard #(
        .MAX_BANKS(MAX_BANKS)
    ) chk (
        .clk      (clk),
        .rst_n    (rst_n),
        .req_valid(req_valid),
        .req_stall(req_stall),
        .req      (req),
        .rsp_valid(rsp_valid),
        .rsp_stall(rsp_stall),
        .rsp      (rsp),
        .cfg_valid(cfg_valid),
        .cfg_ready(cfg_ready),
        .cfg_index(cfg_index),
        .cfg_data (cfg_data),
        .errors   (errors),
        .pending  (pending),
        .words_in (words_in),
        .words_out(words_out)
    );

    initial
    begin
        clk = 1'b0;
        forever #10 clk = ~clk;
    end

    always @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
            rsp_stall <= 1'b0;
        else
            rsp_stall <= !calm && ($urandom_range(99) < 34);
    end

    task automatic send_word(input sbsm_pkg::op_t op, input logic [15:0] a,
                             input logic [7:0] d);
        sbsm_pkg::req_t w;
        w.operation = op;
        w.address   = a;
        w.data      = d;
        if (!calm)
        begin
            while ($urandom_range(99) < 34)
            begin
                req_valid <= 1'b0;
                @(posedge clk);
            end
        end
        req       <= w;
        req_valid <= 1'b1;
        @(posedge clk);
        while (req_stall)
            @(posedge clk);
    endtask

    task automatic load_register(input logic [1:0] tgt, input logic [4:0] value);
        logic [15:0] a;
        int i;
        for (i = 0; i < 5; i++)
        begin
            a        = 16'($urandom);
            a[14:13] = tgt;
            send_word(sbsm_pkg::OP_REG_WRITE, a, {1'b0, 6'($urandom), value[i]});
        end
    endtask

    task automatic drain();
        req_valid <= 1'b0;
        @(posedge clk);
        while (pending != 0)
            @(posedge clk);
        repeat (4) @(posedge clk);
    endtask

    task automatic put_cfg(input logic [1:0] idx, input logic [4:0] value);
        cfg_index <= idx;
        cfg_data  <= value;
        cfg_valid <= 1'b1;
        @(posedge clk);
        while (!cfg_ready)
            @(posedge clk);
    endtask

    task automatic configure(input logic [4:0] banks, input logic ram, input logic [1:0] mir);
        drain();
        put_cfg(sbsm_pkg::CFG_PRG_BANK_COUNT, banks);
        put_cfg(sbsm_pkg::CFG_CHR_IS_RAM, {4'd0, ram});
        put_cfg(sbsm_pkg::CFG_INIT_MIRROR, {3'd0, mir});
        cfg_valid <= 1'b0;
        settings_done++;
    endtask

    task automatic random_traffic(input int count);
        int sent;
        int pick;
        int cut;
        int i;
        logic [15:0] a;
        sent = 0;
        while (sent < count)
        begin
            pick = $urandom_range(99);
            if (pick < 35)
            begin
                load_register(2'($urandom), 5'($urandom));
                sent += 5;
            end
            else if (pick < 42)
            begin
                // abandon a partial load
                cut = $urandom_range(1, 4);
                for (i = 0; i < cut; i++)
                    send_word(sbsm_pkg::OP_REG_WRITE, 16'($urandom), {1'b0, 7'($urandom)});
                send_word(sbsm_pkg::OP_REG_WRITE, 16'($urandom), {1'b1, 7'($urandom)});
                sent += cut + 1;
            end
            else if (pick < 46)
            begin
                send_word(sbsm_pkg::OP_REG_WRITE, 16'($urandom), 8'($urandom));
                sent++;
            end
            else if (pick < 70)
            begin
                a = ($urandom_range(99) < 75) ? {1'b1, 15'($urandom)} : 16'($urandom);
                send_word(sbsm_pkg::OP_PRG_READ, a, 8'($urandom));
                sent++;
            end
            else
            begin
                a = ($urandom_range(99) < 85) ? {3'd0, 13'($urandom)} : 16'($urandom);
                send_word($urandom_range(1) ? sbsm_pkg::OP_CHR_WRITE : sbsm_pkg::OP_CHR_READ,
                          a, 8'($urandom));
                sent++;
            end
            if ($urandom_range(199) == 0)
                drain();
        end
    endtask

    initial
    begin
        rst_n         = 1'b0;
        req_valid     = 1'b0;
        req           = '0;
        cfg_valid     = 1'b0;
        cfg_index     = '0;
        cfg_data      = '0;
        calm          = 1'b0;
        settings_done = 1;
        repeat (5) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        send_word(sbsm_pkg::OP_PRG_READ, 16'h0000, 8'h00);
        send_word(sbsm_pkg::OP_PRG_READ, 16'hBFFF, 8'hFF);
        send_word(sbsm_pkg::OP_PRG_READ, 16'hC000, 8'h00);
        send_word(sbsm_pkg::OP_PRG_READ, 16'hFFFF, 8'hFF);
        send_word(sbsm_pkg::OP_CHR_READ, 16'h0000, 8'h00);
        send_word(sbsm_pkg::OP_CHR_WRITE, 16'h1FFF, 8'hFF);
        send_word(sbsm_pkg::OP_CHR_READ, 16'hFFFF, 8'h00);
        send_word(sbsm_pkg::OP_REG_WRITE, 16'hE000, 8'h01);
        send_word(sbsm_pkg::OP_REG_WRITE, 16'hE000, 8'h80);
        // bit 15 is random here; the target still decodes by bits 14:13
        load_register(sbsm_pkg::TGT_CHR_LOW, 5'h1F);
        load_register(sbsm_pkg::TGT_CONTROL, 5'b10011);
        send_word(sbsm_pkg::OP_CHR_READ, 16'h1000, 8'h00);
        send_word(sbsm_pkg::OP_PRG_READ, 16'hC000, 8'h00);
        send_word(sbsm_pkg::OP_REG_WRITE, 16'hFFFF, 8'hFF);
        send_word(sbsm_pkg::OP_PRG_READ, 16'hC000, 8'h00);

        configure(5'd2, 1'b1, 2'd0);
        random_traffic(PHASE_WORDS);
        configure(5'd0, 1'b0, 2'd3);
        random_traffic(PHASE_WORDS);
        configure(5'd31, 1'b0, 2'd1);
        calm <= 1'b1;
        random_traffic(PHASE_WORDS);
        calm <= 1'b0;
        configure(5'd1, 1'b1, 2'd2);
        random_traffic(PHASE_WORDS);
        configure(5'($urandom_range(3, 15)), 1'($urandom), 2'($urandom));
        random_traffic(PHASE_WORDS);
        configure(5'd16, 1'b0, 2'd2);
        random_traffic(PHASE_WORDS);
        drain();

        $display("Covered %0d bus words and %0d checked results across %0d mapper settings,",
                 words_in, words_out, settings_done);
        $display("including clamped and rounded bank counts and character RAM and ROM.");
        if (errors == 0 && pending == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

    initial
    begin
        #2_000_000;
        $display("timeout waiting for the mapper");
        $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
